// ----- design/vit_pkg.sv -----
// ----------------------------------------------------------------------------
// vit_pkg: shared types and constants
// Transfer payloads, operation codes, register indices and timing constants.
// ----------------------------------------------------------------------------
package vit_pkg;

  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_EVENT = 2'd2;

  localparam logic [3:0] REG_STATUS  = 4'd0;
  localparam logic [3:0] REG_WIDTH   = 4'd2;
  localparam logic [3:0] REG_CURRENT = 4'd4;
  localparam logic [3:0] REG_VSYNC   = 4'd6;

  localparam int unsigned INTERLACE_BIT = 6;

  localparam logic [31:0] LINE_CYCLES    = 32'd1500;
  localparam logic [31:0] DEFAULT_PERIOD = 32'd500000;
  localparam logic [31:0] RESET_PERIOD   = 32'd5000;

  // floor(y / 375) = (y * RECIP_375) >> RECIP_SHIFT, exact for y < 2^30
  localparam logic [30:0] RECIP_375   = 31'd1466015504;
  localparam int unsigned RECIP_SHIFT = 39;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  reg_index;
    logic [31:0] write_data;
    logic [31:0] write_mask;
    logic [31:0] cpu_count;
  } req_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_raise;
    logic        irq_clear;
    logic        status_changed;
    logic        width_changed;
    logic [31:0] next_event_time;
  } rsp_item_t;

endpackage

// ----- design/vit_req_if.sv -----
// ----------------------------------------------------------------------------
// vit_req_if: request channel
// Valid/ready channel carrying one bus access or event per transfer.
// ----------------------------------------------------------------------------
interface vit_req_if;
  logic                valid;
  logic                ready;
  vit_pkg::req_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/vit_rsp_if.sv -----
// ----------------------------------------------------------------------------
// vit_rsp_if: response channel
// Valid/ready channel carrying one result per transfer.
// ----------------------------------------------------------------------------
interface vit_rsp_if;
  logic                valid;
  logic                ready;
  vit_pkg::rsp_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/vit_line_calc.sv -----
// ----------------------------------------------------------------------------
// vit_line_calc: current line computation
// Cycles into the frame divided by 1500 via reciprocal multiply; field in bit 0.
// ----------------------------------------------------------------------------
module vit_line_calc (
  input  logic [31:0] frame_period,
  input  logic [31:0] next_time,
  input  logic [31:0] cpu_count,
  input  logic        field_bit,
  output logic [31:0] line
);

  logic [31:0] span;
  logic [29:0] quarter;
  logic [60:0] prod;
  logic [21:0] quot;

  assign span    = frame_period - (next_time - cpu_count);
  assign quarter = span[31:2];
  assign prod    = {31'd0, quarter} * {30'd0, vit_pkg::RECIP_375};
  assign quot    = prod[60:vit_pkg::RECIP_SHIFT];
  assign line    = {10'd0, quot[21:1], field_bit};

endmodule

// ----- design/vit_core.sv -----
// ----------------------------------------------------------------------------
// vit_core: register bank and frame timing state
// Executes one request per enabled cycle and forms its result.
// ----------------------------------------------------------------------------
module vit_core #(
  parameter int REG_COUNT = 14
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               exec,
  input  vit_pkg::req_item_t item,
  output vit_pkg::rsp_item_t result
);

  localparam int IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  logic [31:0]      bank [REG_COUNT];
  logic             field_bit;
  logic [31:0]      frame_period;
  logic [31:0]      next_time;

  logic             field_bit_next;
  logic [31:0]      frame_period_next;
  logic [31:0]      next_time_next;
  logic             bank_we;
  logic [31:0]      bank_wdata;

  logic             in_range;
  logic [IDX_W-1:0] idx;
  logic [31:0]      cur;
  logic [31:0]      merged;
  logic [31:0]      line;
  logic [31:0]      vsync;
  logic [31:0]      status;
  logic [31:0]      vs_period;
  logic             differs;

  assign in_range = {1'b0, item.reg_index} < 5'(REG_COUNT);
  assign idx      = item.reg_index[IDX_W-1:0];
  assign cur      = in_range ? bank[idx] : 32'd0;
  assign merged   = (cur & ~item.write_mask) | (item.write_data & item.write_mask);
  assign differs  = (cur & item.write_mask) != (item.write_data & item.write_mask);
  assign vsync    = bank[IDX_W'(vit_pkg::REG_VSYNC)];
  assign status   = bank[IDX_W'(vit_pkg::REG_STATUS)];
  assign vs_period = 32'((vsync + 32'd1) * vit_pkg::LINE_CYCLES);

  vit_line_calc u_line (
    .frame_period (frame_period),
    .next_time    (next_time),
    .cpu_count    (item.cpu_count),
    .field_bit    (field_bit),
    .line         (line)
  );

  always_comb begin
    field_bit_next    = field_bit;
    frame_period_next = frame_period;
    next_time_next    = next_time;
    bank_we           = 1'b0;
    bank_wdata        = merged;
    result            = '0;
    case (item.func)
      vit_pkg::FUNC_READ: begin
        if (item.reg_index == vit_pkg::REG_CURRENT) begin
          bank_we          = 1'b1;
          bank_wdata       = line;
          result.read_data = line;
        end else begin
          result.read_data = cur;
        end
      end
      vit_pkg::FUNC_WRITE: begin
        if (in_range) begin
          if (item.reg_index == vit_pkg::REG_STATUS) begin
            bank_we               = 1'b1;
            result.status_changed = differs;
          end else if (item.reg_index == vit_pkg::REG_WIDTH) begin
            bank_we              = 1'b1;
            result.width_changed = differs;
          end else if (item.reg_index == vit_pkg::REG_CURRENT) begin
            result.irq_clear = 1'b1;
          end else begin
            bank_we = 1'b1;
          end
        end
      end
      vit_pkg::FUNC_EVENT: begin
        field_bit_next    = field_bit ^ status[vit_pkg::INTERLACE_BIT];
        frame_period_next = (vsync == 32'd0) ? vit_pkg::DEFAULT_PERIOD : vs_period;
        next_time_next    = next_time + frame_period_next;
        result.irq_raise  = 1'b1;
      end
      default: begin
      end
    endcase
    result.next_event_time = next_time_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        bank[i] <= 32'd0;
      end
      field_bit    <= 1'b0;
      frame_period <= vit_pkg::RESET_PERIOD;
      next_time    <= vit_pkg::RESET_PERIOD;
    end else if (exec) begin
      if (bank_we) begin
        bank[idx] <= bank_wdata;
      end
      field_bit    <= field_bit_next;
      frame_period <= frame_period_next;
      next_time    <= next_time_next;
    end
  end

endmodule

// ----- design/video_interface_register_timer.sv -----
// ----------------------------------------------------------------------------
// video_interface_register_timer: video interface registers and frame timer
// Path: a request is registered at the input, executed by the core, and its result registered at the output.
// Throughput: one request per cycle; a stalled result stops input once two are held.
// One pass: register read/merge, reciprocal multiply for line, period update.
// Reset: synchronous; bank cleared, field 0, period and next event 5000.
// ----------------------------------------------------------------------------
module video_interface_register_timer #(
  parameter int REG_COUNT = 14
) (
  input logic   clk,
  input logic   rst,
  vit_req_if.sink   req,
  vit_rsp_if.source rsp
);

  logic               in_valid;
  vit_pkg::req_item_t in_item;
  logic               out_valid;
  vit_pkg::rsp_item_t out_item;
  vit_pkg::rsp_item_t result;
  logic               advance;

  assign advance   = in_valid && (!out_valid || rsp.ready);
  assign req.ready = !in_valid || advance;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_item;

  vit_core #(.REG_COUNT(REG_COUNT)) u_core (
    .clk    (clk),
    .rst    (rst),
    .exec   (advance),
    .item   (in_item),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_item <= req.data;
    end
    if (advance) begin
      out_item <= result;
    end
  end

endmodule

// ----- design/vit_checker.sv -----
// ----------------------------------------------------------------------------
// vit_checker: port-level checks
// Result hold under stall, flag exclusivity, zero read data on flagged results and event time consistency.
// ----------------------------------------------------------------------------
module vit_checker (
  input logic               clk,
  input logic               rst,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input vit_pkg::rsp_item_t rsp_data
);

  logic [3:0] flags;
  assign flags = {rsp_data.irq_raise, rsp_data.irq_clear,
                  rsp_data.status_changed, rsp_data.width_changed};

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("stalled result changed");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> $countones(flags) <= 1)
    else $error("more than one result flag set");

  a_rdata: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (flags != 4'd0) |-> rsp_data.read_data == 32'd0)
    else $error("read data on non-read result");

  a_time: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_ready) ##1 (rsp_valid && rsp_ready && !rsp_data.irq_raise)
    |-> rsp_data.next_event_time == $past(rsp_data.next_event_time))
    else $error("next event time moved without event");

endmodule

bind video_interface_register_timer vit_checker u_vit_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);

// ----- bench/video_interface_register_timer_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_interface_register_timer_test: register bank and frame timer bench
// Drives reads, masked writes, vertical events and the unused code. A local
// copy of the bank, field, period and next-event time predicts every result,
// which is checked field by field in order. Both channels idle at random, and
// one phase holds the result side off long enough to stall the requests.
// ----------------------------------------------------------------------------
module video_interface_register_timer_test;

  localparam int          BANK_SIZE   = 14;
  localparam logic [1:0]  FUNC_UNUSED = 2'd3;
  localparam int          IDLE_LIMIT  = 2000;
  localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;

  logic clk;
  logic rst;

  vit_req_if req_if();
  vit_rsp_if rsp_if();

  video_interface_register_timer #(.REG_COUNT(BANK_SIZE)) u_top (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  logic [31:0] shadow_regs [BANK_SIZE];
  logic        shadow_field;
  logic [31:0] shadow_period;
  logic [31:0] shadow_next;

  vit_pkg::rsp_item_t pending_rsp_q[$];
  int        error_count;
  int        stall_left;
  int        rsp_hold_cycles;
  int        quiet_cycles;
  bit        src_idle;
  bit        snk_idle;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] bank_value(input logic [3:0] idx);
    return (idx < BANK_SIZE) ? shadow_regs[idx] : 32'd0;
  endfunction

  // Applies one request to the local state and returns the result it causes.
  function automatic vit_pkg::rsp_item_t predict_response(input vit_pkg::req_item_t rq);
    vit_pkg::rsp_item_t r;
    logic [31:0] span;
    logic [31:0] line;
    logic [31:0] status;
    logic [31:0] vs;
    logic [31:0] old;
    r = '0;
    case (rq.func)
      vit_pkg::FUNC_READ: begin
        if (rq.reg_index == vit_pkg::REG_CURRENT) begin
          span = shadow_period - (shadow_next - rq.cpu_count);
          line = span / vit_pkg::LINE_CYCLES;
          line[0] = shadow_field;
          shadow_regs[vit_pkg::REG_CURRENT] = line;
        end
        r.read_data = bank_value(rq.reg_index);
      end
      vit_pkg::FUNC_WRITE: begin
        if (rq.reg_index < BANK_SIZE) begin
          old = shadow_regs[rq.reg_index];
          if (rq.reg_index == vit_pkg::REG_STATUS || rq.reg_index == vit_pkg::REG_WIDTH) begin
            if ((old & rq.write_mask) != (rq.write_data & rq.write_mask)) begin
              shadow_regs[rq.reg_index] = (old & ~rq.write_mask) |
                                          (rq.write_data & rq.write_mask);
              if (rq.reg_index == vit_pkg::REG_STATUS) r.status_changed = 1'b1;
              else r.width_changed = 1'b1;
            end
          end else if (rq.reg_index == vit_pkg::REG_CURRENT) begin
            r.irq_clear = 1'b1;
          end else begin
            shadow_regs[rq.reg_index] = (old & ~rq.write_mask) |
                                        (rq.write_data & rq.write_mask);
          end
        end
      end
      vit_pkg::FUNC_EVENT: begin
        status = bank_value(vit_pkg::REG_STATUS);
        vs = bank_value(vit_pkg::REG_VSYNC);
        shadow_field = shadow_field ^ status[vit_pkg::INTERLACE_BIT];
        shadow_period = (vs == 32'd0) ? vit_pkg::DEFAULT_PERIOD
                                      : (vs + 32'd1) * vit_pkg::LINE_CYCLES;
        shadow_next = shadow_next + shadow_period;
        r.irq_raise = 1'b1;
      end
      default: begin
      end
    endcase
    r.next_event_time = shadow_next;
    return r;
  endfunction

  function automatic vit_pkg::req_item_t make_req(input logic [1:0] func,
                                                  input logic [3:0] idx,
                                                  input logic [31:0] wdata,
                                                  input logic [31:0] wmask,
                                                  input logic [31:0] count);
    vit_pkg::req_item_t rq;
    rq.func       = func;
    rq.reg_index  = idx;
    rq.write_data = wdata;
    rq.write_mask = wmask;
    rq.cpu_count  = count;
    return rq;
  endfunction

  task automatic send_req(input vit_pkg::req_item_t rq);
    int gap;
    gap = src_idle ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      @(negedge clk);
      req_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_if.valid <= 1'b1;
    req_if.data  <= rq;
    do @(posedge clk); while (!req_if.ready);
    pending_rsp_q.push_back(predict_response(rq));
  endtask

  task automatic drain_results();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
      error_count++;
    end
  endtask

  // Result side: stall control at the falling edge.
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (rsp_hold_cycles > 0) begin
        rsp_if.ready <= 1'b0;
        rsp_hold_cycles--;
      end else if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Result check and watchdog at the rising edge.
  initial begin
    vit_pkg::rsp_item_t exp_r;
    forever begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        stall_left = snk_idle ? $urandom_range(0, 8) : 0;
        if (pending_rsp_q.size() == 0) begin
          $display("%0t: unexpected result transfer: actual %h", $time, rsp_if.data);
          error_count++;
        end else begin
          exp_r = pending_rsp_q.pop_front();
          check_field("read_data", exp_r.read_data, rsp_if.data.read_data);
          check_field("irq_raise", 32'(exp_r.irq_raise), 32'(rsp_if.data.irq_raise));
          check_field("irq_clear", 32'(exp_r.irq_clear), 32'(rsp_if.data.irq_clear));
          check_field("status_changed", 32'(exp_r.status_changed),
                      32'(rsp_if.data.status_changed));
          check_field("width_changed", 32'(exp_r.width_changed),
                      32'(rsp_if.data.width_changed));
          check_field("next_event_time", exp_r.next_event_time,
                      rsp_if.data.next_event_time);
        end
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic test_directed();
    src_idle = 1'b1;
    snk_idle = 1'b1;
    send_req(make_req(vit_pkg::FUNC_READ, vit_pkg::REG_CURRENT, '0, '0, 32'd0));
    send_req(make_req(vit_pkg::FUNC_READ, vit_pkg::REG_CURRENT, '0, '0, ALL_ONES));
    send_req(make_req(vit_pkg::FUNC_WRITE, vit_pkg::REG_STATUS, ALL_ONES, 32'd0, '0));
    send_req(make_req(vit_pkg::FUNC_WRITE, vit_pkg::REG_STATUS, 32'h40, ALL_ONES, '0));
    send_req(make_req(vit_pkg::FUNC_WRITE, vit_pkg::REG_STATUS, 32'h40, 32'h40, '0));
    send_req(make_req(vit_pkg::FUNC_WRITE, vit_pkg::REG_WIDTH, ALL_ONES, ALL_ONES, '0));
    send_req(make_req(vit_pkg::FUNC_WRITE, vit_pkg::REG_WIDTH, 32'd0, 32'h0000_FFFF, '0));
    send_req(make_req(vit_pkg::FUNC_READ, vit_pkg::REG_WIDTH, '0, '0, '0));
    send_req(make_req(vit_pkg::FUNC_EVENT, '0, '0, '0, '0));
    send_req(make_req(vit_pkg::FUNC_READ, vit_pkg::REG_CURRENT, '0, '0, 32'd300000));
    send_req(make_req(vit_pkg::FUNC_WRITE, vit_pkg::REG_VSYNC, 32'h20C, ALL_ONES, '0));
    send_req(make_req(vit_pkg::FUNC_EVENT, '0, '0, '0, '0));
    send_req(make_req(vit_pkg::FUNC_READ, vit_pkg::REG_CURRENT, '0, '0, 32'd700000));
    send_req(make_req(vit_pkg::FUNC_WRITE, vit_pkg::REG_CURRENT, ALL_ONES, ALL_ONES, '0));
    send_req(make_req(vit_pkg::FUNC_READ, vit_pkg::REG_CURRENT, '0, '0, 32'd12345));
    send_req(make_req(vit_pkg::FUNC_WRITE, vit_pkg::REG_VSYNC, ALL_ONES, ALL_ONES, '0));
    send_req(make_req(vit_pkg::FUNC_EVENT, '0, '0, '0, '0));
    send_req(make_req(vit_pkg::FUNC_WRITE, 4'd13, 32'hA5A5_5A5A, 32'hFF00_FF00, '0));
    send_req(make_req(vit_pkg::FUNC_READ, 4'd13, '0, '0, '0));
    send_req(make_req(vit_pkg::FUNC_WRITE, 4'd14, ALL_ONES, ALL_ONES, '0));
    send_req(make_req(vit_pkg::FUNC_READ, 4'd14, '0, '0, '0));
    send_req(make_req(vit_pkg::FUNC_READ, 4'd15, '0, '0, '0));
    send_req(make_req(FUNC_UNUSED, vit_pkg::REG_STATUS, ALL_ONES, ALL_ONES, ALL_ONES));
    send_req(make_req(vit_pkg::FUNC_READ, vit_pkg::REG_STATUS, '0, '0, '0));
    drain_results();
  endtask

  task automatic test_random_traffic(input int n_items);
    vit_pkg::req_item_t rq;
    int        sel;
    for (int i = 0; i < n_items; i++) begin
      if (i % 200 == 0) begin
        src_idle = ($urandom_range(0, 3) != 0);
        snk_idle = ($urandom_range(0, 3) != 0);
      end
      sel = $urandom_range(0, 99);
      if (sel < 35) rq.func = vit_pkg::FUNC_READ;
      else if (sel < 72) rq.func = vit_pkg::FUNC_WRITE;
      else if (sel < 97) rq.func = vit_pkg::FUNC_EVENT;
      else rq.func = FUNC_UNUSED;
      case ($urandom_range(0, 5))
        0: rq.reg_index = vit_pkg::REG_STATUS;
        1: rq.reg_index = vit_pkg::REG_WIDTH;
        2: rq.reg_index = vit_pkg::REG_CURRENT;
        3: rq.reg_index = vit_pkg::REG_VSYNC;
        default: rq.reg_index = 4'($urandom_range(0, 15));
      endcase
      rq.write_data = $urandom();
      case ($urandom_range(0, 3))
        0: rq.write_mask = 32'd0;
        1: rq.write_mask = ALL_ONES;
        2: rq.write_mask = 32'd1 << $urandom_range(0, 31);
        default: rq.write_mask = $urandom();
      endcase
      if (rq.reg_index == vit_pkg::REG_VSYNC && $urandom_range(0, 3) != 0) begin
        rq.write_data = $urandom_range(0, 1023);
        rq.write_mask = ALL_ONES;
      end
      rq.cpu_count = $urandom();
      if ($urandom_range(0, 1) == 1)
        rq.cpu_count = shadow_next - $urandom_range(0, shadow_period);
      send_req(rq);
    end
    drain_results();
  endtask

  // Result side held off while requests keep coming, then a full drain, then a burst with random result stalls.
  task automatic test_backpressure();
    src_idle = 1'b0;
    snk_idle = 1'b0;
    @(negedge clk);
    rsp_hold_cycles = 300;
    for (int i = 0; i < 60; i++) begin
      send_req(make_req(2'($urandom_range(0, 2)), 4'($urandom_range(0, 7)), $urandom(),
                        $urandom(), $urandom()));
    end
    drain_results();
    snk_idle = 1'b1;
    for (int i = 0; i < 40; i++) begin
      send_req(make_req(2'($urandom_range(0, 2)), 4'($urandom_range(0, 7)), $urandom(),
                        $urandom(), shadow_next - $urandom_range(0, shadow_period)));
    end
    drain_results();
  endtask

  initial begin
    error_count     = 0;
    stall_left      = 0;
    rsp_hold_cycles = 0;
    quiet_cycles    = 0;
    src_idle        = 1'b0;
    snk_idle        = 1'b0;
    for (int i = 0; i < BANK_SIZE; i++) shadow_regs[i] = 32'd0;
    shadow_field  = 1'b0;
    shadow_period = vit_pkg::RESET_PERIOD;
    shadow_next   = vit_pkg::RESET_PERIOD;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    rst          <= 1'b1;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_traffic(1300);
    test_backpressure();

    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
